FILE: design/ccf_pkg.sv
// shared types, constants and codes of the ceiling grid confirm filter
package ccf_pkg;

	localparam int GRID_SIZE_DEF    = 31;
	localparam int CENTER_WIDTH_DEF = 5;
	localparam int CS_MIN           = 10;
	localparam int DIV_W            = 30;
	localparam int DIV_CNT_W        = 5;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_POINT = 2'd1,
		REQ_POSE  = 2'd2,
		REQ_QUERY = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		SRC_CENTER = 2'd0,
		SRC_RING   = 2'd1,
		SRC_RAW    = 2'd2,
		SRC_NONE   = 2'd3
	} src_t;

	typedef enum logic [2:0] {
		REG_CELL_SIZE  = 3'd0,
		REG_DIVERGENCE = 3'd1,
		REG_CONFIRM    = 3'd2,
		REG_MAX_RANGE  = 3'd3,
		REG_RAW_MIN    = 3'd4,
		REG_RAW_MAX    = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		RD_SCAN  = 2'd0,
		RD_SRC   = 2'd1,
		RD_POINT = 2'd2
	} rd_sel_t;

	typedef enum logic [1:0] {
		SC_FULL       = 2'd0,
		SC_CENTER     = 2'd1,
		SC_RING_FIRST = 2'd2,
		SC_RING_NEXT  = 2'd3
	} scan_mode_t;

	typedef struct packed {
		logic               cv;
		logic               kv;
		logic [7:0]         st;
		logic signed [20:0] ch;
		logic signed [20:0] kh;
	} cell_t;

	typedef struct packed {
		logic       load_req;
		logic       clear_raw;
		logic       set_raw;
		logic       mul;
		logic       div_start;
		logic       div_point;
		logic       div_axis;
		logic       store_q;
		logic       pose_set;
		logic       origin_set;
		logic       bank_flip;
		logic       clr_wr;
		logic       copy_wr;
		logic       cell_wr;
		logic       scan_init;
		scan_mode_t scan_mode;
		logic       scan_next;
		rd_sel_t    rd_sel;
		logic       best_clr;
		logic       best_upd;
		logic       load_out;
		src_t       out_sel;
	} cmd_t;

	typedef struct packed {
		logic pose_known;
		logic origin_known;
		logic gate_ok;
		logic div_busy;
		logic in_grid;
		logic same_origin;
		logic scan_last;
		logic rd_cvalid;
		logic found;
		logic ring_last;
		logic has_outer;
	} stat_t;

endpackage

FILE: design/ccf_ram.sv
// generic simple dual port ram with registered read
module ccf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: design/ccf_div.sv
// serial restoring divider, one quotient bit per cycle, signed result
module ccf_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [ccf_pkg::DIV_W-1:0]          dividend,
	input  logic                               neg,
	input  logic [10:0]                        divisor,
	output logic                               busy,
	output logic signed [ccf_pkg::DIV_W:0]     quo
);

	logic [ccf_pkg::DIV_W-1:0]     num_q;
	logic [10:0]                   rem_q;
	logic [10:0]                   d_q;
	logic                          neg_q;
	logic                          busy_q;
	logic [ccf_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [11:0]                   trial;
	logic                          ge;

	assign trial = {rem_q, num_q[ccf_pkg::DIV_W-1]};
	assign ge    = trial >= {1'b0, d_q};

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == ccf_pkg::DIV_CNT_W'(ccf_pkg::DIV_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// shift and subtract datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
			neg_q <= neg;
		end else if (busy_q) begin
			rem_q <= ge ? 11'(trial - {1'b0, d_q}) : trial[10:0];
			num_q <= {num_q[ccf_pkg::DIV_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});

endmodule

FILE: design/ccf_dp.sv
// datapath: configuration, grid memories, divider, scan counters and result
module ccf_dp #(
	parameter int GRID_SIZE    = ccf_pkg::GRID_SIZE_DEF,
	parameter int CENTER_WIDTH = ccf_pkg::CENTER_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic signed [20:0]  pos_x,
	input  logic signed [20:0]  pos_y,
	input  logic signed [20:0]  pos_z,
	input  ccf_pkg::cmd_t       cmd,
	output ccf_pkg::stat_t      stat,
	output logic [15:0]         range_mm,
	output logic [1:0]          range_source
);

	localparam int HALF      = (GRID_SIZE - 1) / 2;
	localparam int CELLS     = GRID_SIZE * GRID_SIZE;
	localparam int IW        = $clog2(GRID_SIZE);
	localparam int AW        = $clog2(CELLS);
	localparam int CELL_W    = $bits(ccf_pkg::cell_t);
	localparam int CR        = (CENTER_WIDTH / 2 > HALF) ? HALF : CENTER_WIDTH / 2;
	localparam bit HAS_OUTER = (CENTER_WIDTH / 2) < HALF;
	localparam int RING0     = HAS_OUTER ? CENTER_WIDTH / 2 + 1 : HALF;
	localparam logic signed [30:0] QLO  = 31'(-HALF);
	localparam logic signed [30:0] QHI  = 31'(GRID_SIZE - 1 - HALF);
	localparam logic signed [19:0] GLIM = 20'(GRID_SIZE);

	function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] iy,
		input logic [IW-1:0] ix);
		cell_addr = AW'(AW'(iy) * AW'(GRID_SIZE) + AW'(ix));
	endfunction

	// configuration registers
	logic [9:0]  cell_q;
	logic [15:0] div_q;
	logic [7:0]  conf_q;
	logic [15:0] max_q;
	logic [15:0] rmin_q;
	logic [15:0] rmax_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= 10'd100;
			div_q  <= 16'd1000;
			conf_q <= 8'd10;
			max_q  <= 16'd15000;
			rmin_q <= 16'd1000;
			rmax_q <= 16'd20000;
		end else if (cfg_we) begin
			case (ccf_pkg::reg_idx_t'(cfg_index))
				ccf_pkg::REG_CELL_SIZE:  cell_q <= cfg_data[9:0];
				ccf_pkg::REG_DIVERGENCE: div_q  <= cfg_data;
				ccf_pkg::REG_CONFIRM:    conf_q <= cfg_data[7:0];
				ccf_pkg::REG_MAX_RANGE:  max_q  <= cfg_data;
				ccf_pkg::REG_RAW_MIN:    rmin_q <= cfg_data;
				ccf_pkg::REG_RAW_MAX:    rmax_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [9:0] s_eff;
	assign s_eff = (cell_q < 10'(ccf_pkg::CS_MIN)) ? 10'(ccf_pkg::CS_MIN) : cell_q;

	// latched request payload
	logic signed [20:0] x_q, y_q, z_q;

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			x_q <= pos_x;
			y_q <= pos_y;
			z_q <= pos_z;
		end
	end

	// pose and raw point state
	logic signed [17:0] origin_x_q, origin_y_q;
	logic               origin_known_q, pose_known_q, raw_seen_q;
	logic signed [20:0] drone_q, raw_q;
	logic signed [30:0] qx_q, qy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			origin_known_q <= 1'b0;
			pose_known_q   <= 1'b0;
			drone_q        <= '0;
			raw_seen_q     <= 1'b0;
			raw_q          <= '0;
		end else begin
			if (cmd.clear_raw) begin
				raw_seen_q <= 1'b0;
			end else if (cmd.set_raw && !raw_seen_q) begin
				raw_seen_q <= 1'b1;
				raw_q      <= z_q;
			end
			if (cmd.pose_set) begin
				pose_known_q <= 1'b1;
				drone_q      <= z_q;
			end
			if (cmd.origin_set) begin
				origin_known_q <= 1'b1;
				origin_x_q     <= qx_q[17:0];
				origin_y_q     <= qy_q[17:0];
			end
		end
	end

	// height gate on the point
	logic signed [21:0] rise;
	assign rise = 22'(z_q) - 22'(drone_q);

	// origin times cell size, registered before the subtract
	logic signed [28:0] prod_x_q, prod_y_q;

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_x_q <= 29'(origin_x_q) * 29'(signed'({1'b0, s_eff}));
			prod_y_q <= 29'(origin_y_q) * 29'(signed'({1'b0, s_eff}));
		end
	end

	// rounded division operand: 2|n| + s over 2s
	logic signed [20:0] sel_pos;
	logic signed [28:0] sel_prod;
	logic signed [29:0] num_s;
	logic [29:0]        num_mag;
	logic [29:0]        dividend;
	logic signed [30:0] quo;
	logic               div_busy;

	assign sel_pos  = cmd.div_axis ? y_q : x_q;
	assign sel_prod = cmd.div_axis ? prod_y_q : prod_x_q;
	assign num_s    = cmd.div_point ? 30'(sel_pos) - 30'(sel_prod) : 30'(sel_pos);
	assign num_mag  = num_s[29] ? 30'(-num_s) : 30'(num_s);
	assign dividend = {num_mag[28:0], 1'b0} + 30'(s_eff);

	ccf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.neg      (num_s[29]),
		.divisor  ({s_eff, 1'b0}),
		.busy     (div_busy),
		.quo      (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.store_q) begin
			if (cmd.div_axis) begin
				qy_q <= quo;
			end else begin
				qx_q <= quo;
			end
		end
	end

	// point cell position
	logic [IW-1:0] pt_ix, pt_iy;
	logic [AW-1:0] pt_addr;
	logic          in_grid;

	assign in_grid = (qx_q >= QLO) && (qx_q <= QHI) && (qy_q >= QLO) && (qy_q <= QHI);
	assign pt_ix   = qx_q[IW-1:0] + IW'(HALF);
	assign pt_iy   = qy_q[IW-1:0] + IW'(HALF);
	assign pt_addr = cell_addr(pt_iy, pt_ix);

	// scan counters over a box or a ring
	logic [IW-1:0] sx_q, sy_q, lo_q, hi_q, r_q, rn;
	logic          full_q;
	logic          edge_row;
	logic          scan_last;

	assign rn        = r_q + 1'b1;
	assign edge_row  = (sy_q == lo_q) || (sy_q == hi_q);
	assign scan_last = (sx_q == hi_q) && (sy_q == hi_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q   <= '0;
			sy_q   <= '0;
			lo_q   <= '0;
			hi_q   <= IW'(GRID_SIZE - 1);
			r_q    <= '0;
			full_q <= 1'b1;
		end else if (cmd.scan_init) begin
			unique case (cmd.scan_mode)
				ccf_pkg::SC_FULL: begin
					lo_q   <= '0;
					hi_q   <= IW'(GRID_SIZE - 1);
					sx_q   <= '0;
					sy_q   <= '0;
					full_q <= 1'b1;
				end
				ccf_pkg::SC_CENTER: begin
					lo_q   <= IW'(HALF - CR);
					hi_q   <= IW'(HALF + CR);
					sx_q   <= IW'(HALF - CR);
					sy_q   <= IW'(HALF - CR);
					full_q <= 1'b1;
				end
				ccf_pkg::SC_RING_FIRST: begin
					r_q    <= IW'(RING0);
					lo_q   <= IW'(HALF - RING0);
					hi_q   <= IW'(HALF + RING0);
					sx_q   <= IW'(HALF - RING0);
					sy_q   <= IW'(HALF - RING0);
					full_q <= 1'b0;
				end
				ccf_pkg::SC_RING_NEXT: begin
					r_q    <= rn;
					lo_q   <= IW'(HALF) - rn;
					hi_q   <= IW'(HALF) + rn;
					sx_q   <= IW'(HALF) - rn;
					sy_q   <= IW'(HALF) - rn;
					full_q <= 1'b0;
				end
			endcase
		end else if (cmd.scan_next) begin
			if (full_q || edge_row) begin
				if (sx_q == hi_q) begin
					sx_q <= lo_q;
					sy_q <= sy_q + 1'b1;
				end else begin
					sx_q <= sx_q + 1'b1;
				end
			end else if (sx_q == lo_q) begin
				sx_q <= hi_q;
			end else begin
				sx_q <= lo_q;
				sy_q <= sy_q + 1'b1;
			end
		end
	end

	logic [AW-1:0] scan_addr;
	assign scan_addr = cell_addr(sy_q, sx_q);

	// source cell of a re-centre copy
	logic signed [17:0] nx, ny;
	logic signed [18:0] dx, dy;
	logic signed [19:0] src_x, src_y;
	logic               src_ok;
	logic [AW-1:0]      src_addr;

	assign nx       = qx_q[17:0];
	assign ny       = qy_q[17:0];
	assign dx       = 19'(nx) - 19'(origin_x_q);
	assign dy       = 19'(ny) - 19'(origin_y_q);
	assign src_x    = signed'(20'(sx_q)) + 20'(dx);
	assign src_y    = signed'(20'(sy_q)) + 20'(dy);
	assign src_ok   = (src_x >= 0) && (src_x < GLIM) && (src_y >= 0) && (src_y < GLIM);
	assign src_addr = cell_addr(src_y[IW-1:0], src_x[IW-1:0]);

	// two grid banks, re-centring copies from the live bank into the other
	logic                bank_q;
	logic [AW-1:0]       raddr, waddr;
	logic [CELL_W-1:0]   rdata0, rdata1, wdata;
	logic                we_cur, we0, we1;
	ccf_pkg::cell_t      rd_cell, upd_cell;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
		end else if (cmd.bank_flip) begin
			bank_q <= ~bank_q;
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			ccf_pkg::RD_SRC:   raddr = src_addr;
			ccf_pkg::RD_POINT: raddr = pt_addr;
			default:           raddr = scan_addr;
		endcase
	end

	assign rd_cell = ccf_pkg::cell_t'(bank_q ? rdata1 : rdata0);
	assign we_cur  = cmd.clr_wr || cmd.cell_wr;
	assign we0     = (we_cur && !bank_q) || (cmd.copy_wr && bank_q);
	assign we1     = (we_cur && bank_q) || (cmd.copy_wr && !bank_q);
	assign waddr   = cmd.cell_wr ? pt_addr : scan_addr;

	always_comb begin
		if (cmd.cell_wr) begin
			wdata = CELL_W'(upd_cell);
		end else if (cmd.copy_wr && src_ok) begin
			wdata = CELL_W'(rd_cell);
		end else begin
			wdata = '0;
		end
	end

	ccf_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_bank0 (
		.clk   (clk),
		.we    (we0),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata0)
	);

	ccf_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_bank1 (
		.clk   (clk),
		.we    (we1),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata1)
	);

	// confirmation filter on one cell
	logic signed [21:0] rise_c;
	logic signed [20:0] kh_n;
	logic [7:0]         st_n;

	assign rise_c = 22'(z_q) - 22'(rd_cell.ch);
	assign kh_n   = (!rd_cell.kv || z_q < rd_cell.kh) ? z_q : rd_cell.kh;
	assign st_n   = rd_cell.kv ? rd_cell.st + 1'b1 : 8'd1;

	always_comb begin
		upd_cell = rd_cell;
		if (!rd_cell.cv || z_q <= rd_cell.ch) begin
			upd_cell.ch = z_q;
			upd_cell.cv = 1'b1;
			upd_cell.kv = 1'b0;
			upd_cell.st = '0;
		end else if (rise_c > signed'(22'(div_q))) begin
			if (st_n >= conf_q) begin
				upd_cell.ch = kh_n;
				upd_cell.kv = 1'b0;
				upd_cell.st = '0;
			end else begin
				upd_cell.kh = kh_n;
				upd_cell.kv = 1'b1;
				upd_cell.st = st_n;
			end
		end
	end

	// centre minimum
	logic signed [20:0] best_q;
	logic               found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.best_clr) begin
			found_q <= 1'b0;
		end else if (cmd.best_upd && rd_cell.cv && (!found_q || rd_cell.ch < best_q)) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.best_upd && rd_cell.cv && (!found_q || rd_cell.ch < best_q)) begin
			best_q <= rd_cell.ch;
		end
	end

	// result register: clamped clearance or the none value
	logic [15:0]        none_v;
	logic signed [20:0] h_sel;
	logic signed [21:0] clr;
	logic [15:0]        clamp_v;
	logic [15:0]        range_q;
	ccf_pkg::src_t      src_q;

	assign none_v = (max_q == 16'hFFFF) ? 16'hFFFF : max_q + 1'b1;

	always_comb begin
		case (cmd.out_sel)
			ccf_pkg::SRC_CENTER: h_sel = best_q;
			ccf_pkg::SRC_RING:   h_sel = rd_cell.ch;
			default:             h_sel = raw_q;
		endcase
	end

	assign clr = 22'(h_sel) - 22'(drone_q);

	always_comb begin
		if (clr < 0) begin
			clamp_v = '0;
		end else if (clr > signed'(22'(max_q))) begin
			clamp_v = max_q;
		end else begin
			clamp_v = clr[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			if (cmd.out_sel == ccf_pkg::SRC_NONE ||
				(cmd.out_sel == ccf_pkg::SRC_RAW && !raw_seen_q)) begin
				range_q <= none_v;
				src_q   <= ccf_pkg::SRC_NONE;
			end else begin
				range_q <= clamp_v;
				src_q   <= cmd.out_sel;
			end
		end
	end

	assign range_mm     = range_q;
	assign range_source = src_q;

	// status toward the controller
	assign stat.pose_known   = pose_known_q;
	assign stat.origin_known = origin_known_q;
	assign stat.gate_ok      = (rise >= signed'(22'(rmin_q))) && (rise <= signed'(22'(rmax_q)));
	assign stat.div_busy     = div_busy;
	assign stat.in_grid      = in_grid;
	assign stat.same_origin  = (nx == origin_x_q) && (ny == origin_y_q);
	assign stat.scan_last    = scan_last;
	assign stat.rd_cvalid    = rd_cell.cv;
	assign stat.found        = found_q;
	assign stat.ring_last    = (r_q == IW'(HALF));
	assign stat.has_outer    = HAS_OUTER;

endmodule

FILE: design/ccf_ctrl.sv
// controller state machine: sequences requests, divisions, copies and scans
module ccf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [1:0]     req_type,
	output logic           out_valid,
	input  logic           out_ready,
	input  ccf_pkg::stat_t stat,
	output ccf_pkg::cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_GATE,
		ST_MUL,
		ST_DIV_X,
		ST_WAIT_X,
		ST_DIV_Y,
		ST_WAIT_Y,
		ST_P_RD,
		ST_P_UPD,
		ST_PS_DEC,
		ST_CP_RD,
		ST_CP_WR,
		ST_CP_END,
		ST_Q_HOLD,
		ST_Q_RD,
		ST_Q_EV,
		ST_Q_CEND,
		ST_R_RD,
		ST_R_EV,
		ST_Q_RAW
	} state_t;

	state_t state_q, state_d;
	logic   pt_q, pt_d;
	logic   out_valid_q;

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		pt_d    = pt_q;
		cmd.div_point = pt_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr    = 1'b1;
				cmd.scan_next = 1'b1;
				if (stat.scan_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					unique case (ccf_pkg::req_t'(req_type))
						ccf_pkg::REQ_START: cmd.clear_raw = 1'b1;
						ccf_pkg::REQ_POINT: begin
							pt_d    = 1'b1;
							state_d = ST_GATE;
						end
						ccf_pkg::REQ_POSE: begin
							pt_d    = 1'b0;
							state_d = ST_DIV_X;
						end
						ccf_pkg::REQ_QUERY: state_d = ST_Q_HOLD;
					endcase
				end
			end
			ST_GATE: begin
				if (!stat.pose_known || !stat.gate_ok) begin
					state_d = ST_IDLE;
				end else begin
					cmd.set_raw = 1'b1;
					state_d     = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV_X;
			end
			ST_DIV_X: begin
				cmd.div_start = 1'b1;
				state_d       = ST_WAIT_X;
			end
			ST_WAIT_X: begin
				if (!stat.div_busy) begin
					cmd.store_q = 1'b1;
					state_d     = ST_DIV_Y;
				end
			end
			ST_DIV_Y: begin
				cmd.div_axis  = 1'b1;
				cmd.div_start = 1'b1;
				state_d       = ST_WAIT_Y;
			end
			ST_WAIT_Y: begin
				cmd.div_axis = 1'b1;
				if (!stat.div_busy) begin
					cmd.store_q = 1'b1;
					state_d     = pt_q ? ST_P_RD : ST_PS_DEC;
				end
			end
			ST_P_RD: begin
				cmd.rd_sel = ccf_pkg::RD_POINT;
				state_d    = stat.in_grid ? ST_P_UPD : ST_IDLE;
			end
			ST_P_UPD: begin
				cmd.rd_sel  = ccf_pkg::RD_POINT;
				cmd.cell_wr = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_PS_DEC: begin
				cmd.pose_set = 1'b1;
				if (!stat.origin_known) begin
					cmd.origin_set = 1'b1;
					state_d        = ST_IDLE;
				end else if (stat.same_origin) begin
					state_d = ST_IDLE;
				end else begin
					cmd.scan_init = 1'b1;
					cmd.scan_mode = ccf_pkg::SC_FULL;
					state_d       = ST_CP_RD;
				end
			end
			ST_CP_RD: begin
				cmd.rd_sel = ccf_pkg::RD_SRC;
				state_d    = ST_CP_WR;
			end
			ST_CP_WR: begin
				cmd.rd_sel    = ccf_pkg::RD_SRC;
				cmd.copy_wr   = 1'b1;
				cmd.scan_next = 1'b1;
				state_d       = stat.scan_last ? ST_CP_END : ST_CP_RD;
			end
			ST_CP_END: begin
				cmd.origin_set = 1'b1;
				cmd.bank_flip  = 1'b1;
				state_d        = ST_IDLE;
			end
			ST_Q_HOLD: begin
				if (!out_valid_q) begin
					if (!stat.pose_known) begin
						cmd.load_out = 1'b1;
						cmd.out_sel  = ccf_pkg::SRC_NONE;
						state_d      = ST_IDLE;
					end else begin
						cmd.scan_init = 1'b1;
						cmd.scan_mode = ccf_pkg::SC_CENTER;
						cmd.best_clr  = 1'b1;
						state_d       = ST_Q_RD;
					end
				end
			end
			ST_Q_RD: state_d = ST_Q_EV;
			ST_Q_EV: begin
				cmd.best_upd  = 1'b1;
				cmd.scan_next = 1'b1;
				state_d       = stat.scan_last ? ST_Q_CEND : ST_Q_RD;
			end
			ST_Q_CEND: begin
				if (stat.found) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = ccf_pkg::SRC_CENTER;
					state_d      = ST_IDLE;
				end else if (stat.has_outer) begin
					cmd.scan_init = 1'b1;
					cmd.scan_mode = ccf_pkg::SC_RING_FIRST;
					state_d       = ST_R_RD;
				end else begin
					state_d = ST_Q_RAW;
				end
			end
			ST_R_RD: state_d = ST_R_EV;
			ST_R_EV: begin
				if (stat.rd_cvalid) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = ccf_pkg::SRC_RING;
					state_d      = ST_IDLE;
				end else if (stat.scan_last) begin
					if (stat.ring_last) begin
						state_d = ST_Q_RAW;
					end else begin
						cmd.scan_init = 1'b1;
						cmd.scan_mode = ccf_pkg::SC_RING_NEXT;
						state_d       = ST_R_RD;
					end
				end else begin
					cmd.scan_next = 1'b1;
					state_d       = ST_R_RD;
				end
			end
			ST_Q_RAW: begin
				cmd.load_out = 1'b1;
				cmd.out_sel  = ccf_pkg::SRC_RAW;
				state_d      = ST_IDLE;
			end
		endcase
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			pt_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pt_q    <= pt_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

FILE: design/ceiling_grid_confirm_filter.sv
// top level of the ceiling grid confirm filter
//
// input channel (in_valid/in_ready) carries one request per transfer:
// cloud start, point sample, pose update or cloud-end query. only a query
// makes a result, sent on the output channel (out_valid/out_ready) as
// range_mm and range_source. configuration is a plain write port (cfg_we,
// cfg_index, cfg_data); the user must write it only while the block is idle,
// which the block itself does not enforce. work per request: a cloud start
// only clears the raw point; a point goes through the gate, a multiply, two
// 30-step serial divisions by the cell size and a read-modify-write of the
// cell; a pose takes the two divisions and, when the origin cell moves, a
// copy of the grid cell by cell into the spare memory bank; a query scans
// the cells one at a time through the single read port of the grid memory.
// after reset a clearing pass writes every cell of the live bank, one per
// cycle, GRID_SIZE^2 cells (961 at the default size), with in_ready low.
// the result sits in an output register; requests other than a query keep
// flowing while the receiver stalls, a new query waits for the slot.
module ceiling_grid_confirm_filter #(
	parameter int GRID_SIZE    = ccf_pkg::GRID_SIZE_DEF,
	parameter int CENTER_WIDTH = ccf_pkg::CENTER_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic signed [20:0] pos_x,
	input  logic signed [20:0] pos_y,
	input  logic signed [20:0] pos_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        range_mm,
	output logic [1:0]         range_source,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	ccf_pkg::cmd_t  cmd;
	ccf_pkg::stat_t stat;

	// sequencing
	ccf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// storage and arithmetic
	ccf_dp #(.GRID_SIZE(GRID_SIZE), .CENTER_WIDTH(CENTER_WIDTH)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.cmd          (cmd),
		.stat         (stat),
		.range_mm     (range_mm),
		.range_source (range_source)
	);

endmodule

FILE: design/ccf_chk.sv
// port checker of the ceiling grid confirm filter and its bind
module ccf_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  req_type,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] range_mm,
	input logic [1:0]  range_source
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(range_mm) && $stable(range_source))
		else $error("result changed while stalled");

	// a query transfer keeps the block busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && req_type == ccf_pkg::REQ_QUERY |=> !in_ready)
		else $error("ready right after a query");

	// a point transfer keeps the block busy
	a_point_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && req_type == ccf_pkg::REQ_POINT |=> !in_ready)
		else $error("ready right after a point");

	// a result appears only at the end of work
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without a busy cycle");

endmodule

bind ceiling_grid_confirm_filter ccf_chk u_chk (.*);
